// ----- hw/rtl/link_keepalive_backoff_supervisor_core_defines.svh -----
// assertion helpers used by the supervisor engine rtl
`ifndef LINK_KEEPALIVE_BACKOFF_SUPERVISOR_CORE_DEFINES_SVH
`define LINK_KEEPALIVE_BACKOFF_SUPERVISOR_CORE_DEFINES_SVH

// same-cycle implication
`define LLBS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/llbs_pkg.sv -----
package llbs_pkg;

   localparam int TIME_W = 32;
   localparam int MS_W   = 20;
   localparam int RND_W  = 11;
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 32;

   // request kinds
   localparam logic [2:0] REQ_TICK   = 3'd0;
   localparam logic [2:0] REQ_OPENED = 3'd1;
   localparam logic [2:0] REQ_MSG    = 3'd2;
   localparam logic [2:0] REQ_PONG   = 3'd3;
   localparam logic [2:0] REQ_LOST   = 3'd4;
   localparam logic [2:0] REQ_PAUSE  = 3'd5;
   localparam logic [2:0] REQ_RESUME = 3'd6;

   // reported phase
   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_HANDSHAKE = 2'd1;
   localparam logic [1:0] PHASE_ACTIVE    = 2'd2;
   localparam logic [1:0] PHASE_PAUSED    = 2'd3;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PING_INTERVAL = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MSG_TIMEOUT   = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_HS_TIMEOUT    = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKOFF_BASE  = 8'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACKOFF_MAX   = 8'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_DELAY    = 8'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_RESUME_DELAY  = 8'd6;

   // register reset values
   localparam logic [MS_W-1:0] RST_PING_INTERVAL = 20'd15000;
   localparam logic [MS_W-1:0] RST_MSG_TIMEOUT   = 20'd30000;
   localparam logic [MS_W-1:0] RST_HS_TIMEOUT    = 20'd15000;
   localparam logic [MS_W-1:0] RST_BACKOFF_BASE  = 20'd5000;
   localparam logic [MS_W-1:0] RST_BACKOFF_MAX   = 20'd60000;
   localparam logic [MS_W-1:0] RST_INIT_DELAY    = 20'd2000;
   localparam logic [MS_W-1:0] RST_RESUME_DELAY  = 20'd1000;

   localparam logic [RND_W-1:0] JITTER_MOD  = 11'd1000;
   localparam logic [RND_W-1:0] JITTER_MOD2 = 11'd2000;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   typedef struct packed {
      logic [MS_W-1:0] ping_interval;
      logic [MS_W-1:0] msg_timeout;
      logic [MS_W-1:0] hs_timeout;
      logic [MS_W-1:0] backoff_base;
      logic [MS_W-1:0] backoff_max;
      logic [MS_W-1:0] init_delay;
      logic [MS_W-1:0] resume_delay;
   } cfg_type;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [TIME_W-1:0] now_ms;
      logic              link_up;
      logic              server_reachable;
      logic [RND_W-1:0]  random_bits;
   } item_type;

   typedef struct packed {
      logic              send_ping;
      logic              close_link;
      logic              open_link;
      logic              probe_failed;
      logic [1:0]        phase;
      logic [MS_W-1:0]   backoff_now_ms;
      logic [TIME_W-1:0] next_attempt_ms;
   } result_type;

endpackage

// ----- hw/rtl/link_keepalive_backoff_supervisor_core.sv -----
// link keepalive and reconnect backoff supervisor
// a request beat passes through the input register and then the result register
// rsp_tvalid rises when the beat is written from the input register into the result register
// throughput: one beat per cycle while the result side keeps taking beats
// reset is synchronous and active high: registers go to their defaults; the input and result data are not reset
module link_keepalive_backoff_supervisor_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // now_ms[31:0], link_up[32], server_reachable[33], random_bits[44:34], zero fill
   input  logic [llbs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_type[2:0]
   input  logic [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // send_ping[0], close_link[1], open_link[2], probe_failed[3], phase[5:4],
   // backoff_now_ms[25:6], next_attempt_ms[57:26], zero fill
   output logic [llbs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [llbs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [llbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import llbs_pkg::*;

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       out_valid_ff;
   result_type out_res_ff;
   logic       out_free;
   logic       fire;
   cfg_type    cfg;
   result_type res;
   item_type   req_item;

   assign req_item.req_type         = req_tuser;
   assign req_item.now_ms           = req_tdata[31:0];
   assign req_item.link_up          = req_tdata[32];
   assign req_item.server_reachable = req_tdata[33];
   assign req_item.random_bits      = req_tdata[44:34];

   // result slot frees when empty or being taken this cycle
   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   llbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   llbs_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cfg    (cfg),
      .item   (in_item_ff),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0,
                        out_res_ff.next_attempt_ms,
                        out_res_ff.backoff_now_ms,
                        out_res_ff.phase,
                        out_res_ff.probe_failed,
                        out_res_ff.open_link,
                        out_res_ff.close_link,
                        out_res_ff.send_ping};

endmodule

// ----- hw/rtl/llbs_csr.sv -----
module llbs_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [llbs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [llbs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output llbs_pkg::cfg_type               cfg
);
   import llbs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_addr)
            CSR_PING_INTERVAL: cfg_in.ping_interval = csr_wdata[MS_W-1:0];
            CSR_MSG_TIMEOUT:   cfg_in.msg_timeout   = csr_wdata[MS_W-1:0];
            CSR_HS_TIMEOUT:    cfg_in.hs_timeout    = csr_wdata[MS_W-1:0];
            CSR_BACKOFF_BASE:  cfg_in.backoff_base  = csr_wdata[MS_W-1:0];
            CSR_BACKOFF_MAX:   cfg_in.backoff_max   = csr_wdata[MS_W-1:0];
            CSR_INIT_DELAY:    cfg_in.init_delay    = csr_wdata[MS_W-1:0];
            CSR_RESUME_DELAY:  cfg_in.resume_delay  = csr_wdata[MS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_interval <= RST_PING_INTERVAL;
         cfg_ff.msg_timeout   <= RST_MSG_TIMEOUT;
         cfg_ff.hs_timeout    <= RST_HS_TIMEOUT;
         cfg_ff.backoff_base  <= RST_BACKOFF_BASE;
         cfg_ff.backoff_max   <= RST_BACKOFF_MAX;
         cfg_ff.init_delay    <= RST_INIT_DELAY;
         cfg_ff.resume_delay  <= RST_RESUME_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/llbs_engine.sv -----
`include "link_keepalive_backoff_supervisor_core_defines.svh"

module llbs_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  llbs_pkg::cfg_type     cfg,
   input  llbs_pkg::item_type    item,
   output llbs_pkg::result_type  result
);
   import llbs_pkg::*;

   logic              started_ff, started_in;
   logic              paused_ff, paused_in;
   logic              resume_wanted_ff, resume_wanted_in;
   logic              link_begun_ff, link_begun_in;
   logic [TIME_W-1:0] last_msg_ff, last_msg_in;
   logic [TIME_W-1:0] last_ping_ff, last_ping_in;
   logic [TIME_W-1:0] begin_time_ff, begin_time_in;
   logic [TIME_W-1:0] next_attempt_ff, next_attempt_in;
   logic [MS_W-1:0]   backoff_ff, backoff_in;

   logic [TIME_W-1:0] now;
   logic [TIME_W-1:0] sched;
   logic [TIME_W-1:0] sched_idle;
   logic [TIME_W-1:0] resched_time;
   logic [RND_W-1:0]  jitter;
   logic [MS_W:0]     doubled;
   logic [MS_W-1:0]   capped;
   logic              ping_due;
   logic              msg_expired;
   logic              hs_expired;

   assign now = item.now_ms;

   // random_bits mod 1000, the value never reaches 3000
   always_comb begin
      if (item.random_bits >= JITTER_MOD2) begin
         jitter = item.random_bits - JITTER_MOD2;
      end else if (item.random_bits >= JITTER_MOD) begin
         jitter = item.random_bits - JITTER_MOD;
      end else begin
         jitter = item.random_bits;
      end
   end

   assign doubled = {backoff_ff, 1'b0};
   assign capped  = (doubled < {1'b0, cfg.backoff_max}) ? doubled[MS_W-1:0] : cfg.backoff_max;
   assign resched_time = now + {{(TIME_W-MS_W){1'b0}}, backoff_ff}
                             + {{(TIME_W-RND_W){1'b0}}, jitter};

   // the very first beat seeds the schedule from the initial delay
   assign sched = started_ff ? next_attempt_ff
                             : now + {{(TIME_W-MS_W){1'b0}}, cfg.init_delay};
   assign sched_idle = (sched == '0) ? now + {{(TIME_W-MS_W){1'b0}}, backoff_ff} : sched;

   assign ping_due    = (last_ping_ff == '0) ||
                        ((now - last_ping_ff) >= {{(TIME_W-MS_W){1'b0}}, cfg.ping_interval});
   assign msg_expired = (now - last_msg_ff) >= {{(TIME_W-MS_W){1'b0}}, cfg.msg_timeout};
   assign hs_expired  = (now - begin_time_ff) >= {{(TIME_W-MS_W){1'b0}}, cfg.hs_timeout};

   always_comb begin
      started_in       = 1'b1;
      paused_in        = paused_ff;
      resume_wanted_in = resume_wanted_ff;
      link_begun_in    = link_begun_ff;
      last_msg_in      = last_msg_ff;
      last_ping_in     = last_ping_ff;
      begin_time_in    = begin_time_ff;
      next_attempt_in  = sched;
      backoff_in       = backoff_ff;
      result           = '0;

      unique case (item.req_type)
         REQ_TICK: begin
            if (paused_ff) begin
               if (item.link_up || link_begun_ff) begin
                  result.close_link = 1'b1;
                  link_begun_in     = 1'b0;
                  backoff_in        = cfg.backoff_base;
               end
               if (resume_wanted_ff) begin
                  resume_wanted_in = 1'b0;
                  paused_in        = 1'b0;
                  next_attempt_in  = now + {{(TIME_W-MS_W){1'b0}}, cfg.resume_delay};
               end
            end else if (link_begun_ff && item.link_up) begin
               if (ping_due) begin
                  result.send_ping = 1'b1;
                  last_ping_in     = now;
               end
               if (msg_expired) begin
                  result.close_link = 1'b1;
                  link_begun_in     = 1'b0;
                  last_ping_in      = '0;
                  next_attempt_in   = resched_time;
                  backoff_in        = capped;
               end
            end else if (link_begun_ff) begin
               if (hs_expired) begin
                  result.close_link = 1'b1;
                  link_begun_in     = 1'b0;
                  last_ping_in      = '0;
                  next_attempt_in   = resched_time;
                  backoff_in        = capped;
               end
            end else begin
               next_attempt_in = sched_idle;
               if (now >= sched_idle) begin
                  if (!item.server_reachable) begin
                     result.probe_failed = 1'b1;
                  end else begin
                     result.open_link = 1'b1;
                     link_begun_in    = 1'b1;
                     begin_time_in    = now;
                     last_ping_in     = '0;
                  end
                  next_attempt_in = resched_time;
                  backoff_in      = capped;
               end
            end
         end
         REQ_OPENED: begin
            if (link_begun_ff) begin
               last_msg_in  = now;
               last_ping_in = now;
               backoff_in   = cfg.backoff_base;
            end
         end
         REQ_MSG: begin
            if (link_begun_ff) begin
               last_msg_in = now;
            end
         end
         REQ_PONG: begin
            if (link_begun_ff) begin
               last_msg_in  = now;
               last_ping_in = now;
            end
         end
         REQ_LOST: begin
            if (link_begun_ff) begin
               link_begun_in   = 1'b0;
               last_ping_in    = '0;
               backoff_in      = cfg.backoff_base;
               next_attempt_in = now + {{(TIME_W-MS_W){1'b0}}, cfg.backoff_base};
            end
         end
         REQ_PAUSE: begin
            resume_wanted_in = 1'b0;
            paused_in        = 1'b1;
         end
         REQ_RESUME: begin
            resume_wanted_in = 1'b1;
         end
         default: begin
            paused_in = paused_ff;
         end
      endcase

      if (paused_in) begin
         result.phase = PHASE_PAUSED;
      end else if (!link_begun_in) begin
         result.phase = PHASE_IDLE;
      end else if (item.link_up) begin
         result.phase = PHASE_ACTIVE;
      end else begin
         result.phase = PHASE_HANDSHAKE;
      end
      result.backoff_now_ms  = backoff_in;
      result.next_attempt_ms = next_attempt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff       <= 1'b0;
         paused_ff        <= 1'b0;
         resume_wanted_ff <= 1'b0;
         link_begun_ff    <= 1'b0;
         last_msg_ff      <= '0;
         last_ping_ff     <= '0;
         begin_time_ff    <= '0;
         next_attempt_ff  <= '0;
         backoff_ff       <= RST_BACKOFF_BASE;
      end else if (fire) begin
         started_ff       <= started_in;
         paused_ff        <= paused_in;
         resume_wanted_ff <= resume_wanted_in;
         link_begun_ff    <= link_begun_in;
         last_msg_ff      <= last_msg_in;
         last_ping_ff     <= last_ping_in;
         begin_time_ff    <= begin_time_in;
         next_attempt_ff  <= next_attempt_in;
         backoff_ff       <= backoff_in;
      end
   end

   `LLBS_ASSERT_NEXT(a_started_after_beat, clock, reset, fire, started_ff, "beat left block unstarted")
   `LLBS_ASSERT_SAME(a_actions_exclusive, clock, reset, fire, $onehot0({result.close_link, result.open_link, result.probe_failed}), "conflicting link actions")
   `LLBS_ASSERT_NEXT(a_open_begins_link, clock, reset, fire && result.open_link, link_begun_ff && (begin_time_ff == $past(now)), "open did not begin link")
   `LLBS_ASSERT_NEXT(a_pause_holds, clock, reset, fire && (item.req_type == REQ_PAUSE), paused_ff && !resume_wanted_ff, "pause request not taken")

endmodule
